// ===== design/oaids_pkg.sv =====
`default_nettype none
package oaids_pkg;

	localparam int DEF_CAPACITY   = 128;
	localparam int DEF_WORD_WIDTH = 32;

	// Stream widths: tdata fields packed from bit 0 up, padded to whole bytes.
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;
	localparam int TUSER_W     = 3;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_READ   = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_SEARCH = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_PUT,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic [7:0]  found_position;
		logic [7:0]  element_count;
	} res_t;

endpackage
`default_nettype wire

// ===== design/oaids_ram.sv =====
`default_nettype none
module oaids_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/oaids_ctrl.sv =====
`default_nettype none
module oaids_ctrl #(
	parameter int CAPACITY   = 128,
	parameter int WORD_WIDTH = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [2:0]           in_action,
	input  wire [7:0]           in_pos,
	input  wire [31:0]          in_value,
	input  wire                 out_free,
	output logic                res_valid,
	output oaids_pkg::res_t     res
);
	import oaids_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int VW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

	ctrl_state_t state_q, state_d;

	logic [2:0]      act_q;
	logic [7:0]      pos_q;
	logic [31:0]     val_q;
	logic [CW-1:0]   count_q, count_d;

	logic [AW-1:0]   rd_idx_q, rd_idx_d;
	logic [AW-1:0]   rd_last_q, rd_last_d;
	logic            rd_more_q, rd_more_d;
	logic            vld_s1, vld_d;
	logic [AW-1:0]   addr_s1;

	status_t         status_q, status_d;
	logic [31:0]     rdval_q, rdval_d;
	logic [7:0]      found_q, found_d;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr;
	logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

	logic [XW-1:0]   pos_x, cnt_x, p0_x, found_x;
	logic [AW-1:0]   p0, cnt_m1;
	logic            is_full, is_empty, pos_in_count, pos_in_insert, scan_down;
	logic [WORD_WIDTH-1:0] word_in;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign p0_x   = pos_x - XW'(1);
	assign p0     = p0_x[AW-1:0];
	assign cnt_m1 = AW'(count_q - CW'(1));
	assign found_x = XW'(addr_s1) + XW'(1);

	assign is_full       = (count_q == CW'(CAPACITY));
	assign is_empty      = (count_q == '0);
	assign pos_in_count  = (pos_q != 8'd0) && (pos_x <= cnt_x);
	assign pos_in_insert = (pos_q != 8'd0) && (pos_x <= cnt_x + XW'(1));
	assign scan_down     = (act_q == ACT_INSERT);

	// Stored words keep only their low bits; the same cut applies to the search key.
	assign word_in = WORD_WIDTH'(val_q[VW-1:0]);

	oaids_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_more_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_more_q <= rd_more_d;
			vld_s1    <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q <= in_action;
			pos_q <= in_pos;
			val_q <= in_value;
		end
		rd_idx_q  <= rd_idx_d;
		rd_last_q <= rd_last_d;
		addr_s1   <= rd_idx_q;
		status_q  <= status_d;
		rdval_q   <= rdval_d;
		found_q   <= found_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_idx_d  = rd_idx_q;
		rd_last_d = rd_last_q;
		rd_more_d = rd_more_q;
		vld_d     = 1'b0;
		status_d  = status_q;
		rdval_d   = rdval_q;
		found_d   = found_q;
		mem_we    = 1'b0;
		mem_waddr = p0;
		mem_wdata = word_in;
		mem_re    = 1'b0;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d  = S_FINISH;
				status_d = ST_OK;
				rdval_d  = '0;
				found_d  = '0;
				unique case (act_q)
					ACT_CLEAR: begin
						count_d = '0;
					end
					ACT_APPEND: begin
						if (is_full) begin
							status_d = ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							count_d   = count_q + CW'(1);
						end
					end
					ACT_READ: begin
						if (is_empty) begin
							status_d = ST_EMPTY;
						end else if (!pos_in_count) begin
							status_d = ST_BADPOS;
						end else begin
							rd_idx_d  = p0;
							rd_last_d = p0;
							rd_more_d = 1'b1;
							state_d   = S_SCAN;
						end
					end
					ACT_INSERT: begin
						if (is_full) begin
							status_d = ST_FULL;
						end else if (!pos_in_insert) begin
							status_d = ST_BADPOS;
						end else if (p0_x == cnt_x) begin
							state_d = S_PUT;
						end else begin
							rd_idx_d  = cnt_m1;
							rd_last_d = p0;
							rd_more_d = 1'b1;
							state_d   = S_SCAN;
						end
					end
					ACT_DELETE: begin
						if (is_empty) begin
							status_d = ST_EMPTY;
						end else if (!pos_in_count) begin
							status_d = ST_BADPOS;
						end else if (p0 == cnt_m1) begin
							count_d = count_q - CW'(1);
						end else begin
							rd_idx_d  = p0 + AW'(1);
							rd_last_d = cnt_m1;
							rd_more_d = 1'b1;
							state_d   = S_SCAN;
						end
					end
					ACT_SEARCH: begin
						if (is_empty) begin
							status_d = ST_EMPTY;
						end else begin
							rd_idx_d  = '0;
							rd_last_d = cnt_m1;
							rd_more_d = 1'b1;
							state_d   = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				// One read issued per cycle; the word read last cycle is used now.
				mem_re = rd_more_q;
				if (rd_more_q) begin
					if (rd_idx_q == rd_last_q) begin
						rd_more_d = 1'b0;
					end else if (scan_down) begin
						rd_idx_d = rd_idx_q - AW'(1);
					end else begin
						rd_idx_d = rd_idx_q + AW'(1);
					end
				end
				if (vld_s1) begin
					unique case (act_q)
						ACT_READ: begin
							rdval_d = 32'(mem_rdata[VW-1:0]);
							state_d = S_FINISH;
						end
						ACT_INSERT: begin
							mem_we    = 1'b1;
							mem_waddr = addr_s1 + AW'(1);
							mem_wdata = mem_rdata;
							if (!rd_more_q) begin
								state_d = S_PUT;
							end
						end
						ACT_DELETE: begin
							mem_we    = 1'b1;
							mem_waddr = addr_s1 - AW'(1);
							mem_wdata = mem_rdata;
							if (!rd_more_q) begin
								count_d = count_q - CW'(1);
								state_d = S_FINISH;
							end
						end
						default: begin
							if (mem_rdata == word_in) begin
								status_d = ST_OK;
								found_d  = found_x[7:0];
								state_d  = S_FINISH;
							end else if (!rd_more_q) begin
								status_d = ST_NOTFOUND;
								state_d  = S_FINISH;
							end
						end
					endcase
				end
				if (state_d != S_SCAN) begin
					rd_more_d = 1'b0;
				end else begin
					vld_d = rd_more_q;
				end
			end
			S_PUT: begin
				mem_we  = 1'b1;
				count_d = count_q + CW'(1);
				state_d = S_FINISH;
			end
			S_FINISH: begin
				res_valid = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	logic [XW-1:0] cnt_out_x;
	assign cnt_out_x = XW'(count_q);

	assign res.status         = status_q;
	assign res.read_value     = rdval_q;
	assign res.found_position = found_q;
	assign res.element_count  = cnt_out_x[7:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(count_q))
		else $error("element count changed without a request in progress");

	a_pipe_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == S_SCAN)
		else $error("read pipeline busy outside a scan");

	a_read_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_more_q |-> state_q == S_SCAN)
		else $error("scan reads pending outside a scan");

endmodule
`default_nettype wire

// ===== design/ordered_array_insert_delete_search.sv =====
// Channel | Dir | tdata (low bit up)                                      | tuser
// s_      | in  | position[7:0], value[39:8], zero[47:40]                 | action[2:0]
// m_      | out | read_value[31:0], found_position[39:32], count[47:40]   | status[2:0]
//
// Clear, append, unused codes and rejected requests go from decide straight to finish.
// Read scans one word; delete shifts later words down (none when the last word goes),
// insert shifts words up (none at the end) and puts the new word; search ends at a match.
// Reset clears the count, not the word memory, which needs no clearing pass.
// A result waits in the output register while the next item is taken and worked on; if
// m_tready stays low, the next result holds in its last cycle and no input is taken.
`default_nettype none
module ordered_array_insert_delete_search #(
	parameter int CAPACITY   = oaids_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = oaids_pkg::DEF_WORD_WIDTH
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [oaids_pkg::IN_TDATA_W-1:0]    s_tdata,  // position, value, zero pad
	input  wire [oaids_pkg::TUSER_W-1:0]       s_tuser,  // action
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [oaids_pkg::OUT_TDATA_W-1:0]  m_tdata,  // read_value, found_position, count
	output logic [oaids_pkg::TUSER_W-1:0]      m_tuser   // status
);
	import oaids_pkg::*;

	logic  m_valid_q;
	res_t  res_q;
	res_t  res_c;
	logic  res_valid;
	logic  out_free;

	assign out_free = !m_valid_q || m_tready;

	oaids_ctrl #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_pos    (s_tdata[7:0]),
		.in_value  (s_tdata[39:8]),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {res_q.element_count, res_q.found_position, res_q.read_value};

endmodule
`default_nettype wire

// ===== tb/sv/ordered_array_insert_delete_search_tb.sv =====
`default_nettype none
module ordered_array_insert_delete_search_tb;
	import oaids_pkg::*;

	localparam int CAPACITY    = DEF_CAPACITY;
	localparam int TOTAL_ITEMS = 1850;
	localparam int STALL_LIMIT = 4000;
	localparam int FILL_EVERY  = 600;

	// Action codes the block does not define; they must still yield an ok result.
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	class array_scoreboard;
		logic [31:0] words [DEF_CAPACITY];
		int unsigned n_words;
		res_t        expected_q [$];
		int          errors;
		int          checked;

		function new();
			n_words = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Applies one accepted request to the array copy and queues its result.
		function void note_request(logic [2:0] act, logic [7:0] pos, logic [31:0] val);
			res_t r;
			int   p;
			int   i;
			r = '0;
			r.status = ST_OK;
			p = pos;
			case (act)
				ACT_CLEAR: begin
					n_words = 0;
				end
				ACT_APPEND: begin
					if (n_words >= DEF_CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						words[n_words] = val;
						n_words++;
					end
				end
				ACT_READ: begin
					if (n_words == 0)
						r.status = ST_EMPTY;
					else if (p < 1 || p > n_words)
						r.status = ST_BADPOS;
					else
						r.read_value = words[p - 1];
				end
				ACT_INSERT: begin
					if (n_words >= DEF_CAPACITY) begin
						r.status = ST_FULL;
					end else if (p < 1 || p > n_words + 1) begin
						r.status = ST_BADPOS;
					end else begin
						for (i = n_words; i >= p; i--)
							words[i] = words[i - 1];
						words[p - 1] = val;
						n_words++;
					end
				end
				ACT_DELETE: begin
					if (n_words == 0) begin
						r.status = ST_EMPTY;
					end else if (p < 1 || p > n_words) begin
						r.status = ST_BADPOS;
					end else begin
						for (i = p - 1; i + 1 < n_words; i++)
							words[i] = words[i + 1];
						n_words--;
					end
				end
				ACT_SEARCH: begin
					if (n_words == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.status = ST_NOTFOUND;
						for (i = 0; i < n_words; i++) begin
							if (words[i] == val) begin
								r.status = ST_OK;
								r.found_position = 8'(i + 1);
								break;
							end
						end
					end
				end
				default: ;
			endcase
			r.element_count = n_words[7:0];
			expected_q.push_back(r);
		endfunction

		task report_mismatch(input string msg);
			errors++;
			$display("mismatch at result %0d: %s", checked, msg);
		endtask

		task check_result(input status_t status, input logic [31:0] rd,
				input logic [7:0] found, input logic [7:0] cnt);
			res_t want;
			checked++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d count %0d",
					status, cnt));
				return;
			end
			want = expected_q.pop_front();
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
			if (rd !== want.read_value)
				report_mismatch($sformatf("read_value %h, expected %h", rd, want.read_value));
			if (found !== want.found_position)
				report_mismatch($sformatf("found_position %0d, expected %0d",
					found, want.found_position));
			if (cnt !== want.element_count)
				report_mismatch($sformatf("element_count %0d, expected %0d",
					cnt, want.element_count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	wire  [47:0] m_tdata;
	wire  [2:0]  m_tuser;

	array_scoreboard sb = new();
	int items_sent = 0;
	int burst_left = 0;

	ordered_array_insert_delete_search u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // position[7:0], value[39:8], zero[47:40]
		.s_tuser  (s_tuser),   // action[2:0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // read_value[31:0], found_position[39:32], count[47:40]
		.m_tuser  (m_tuser)    // status[2:0]
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offers one item, with the burst and gap pattern of the sender, and waits for it
	// to be taken.
	task send_item(input logic [2:0] act, input logic [7:0] pos, input logic [31:0] val);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = 150;
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {8'h00, val, pos};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, pos, val);
		items_sent++;
	endtask

	// Mostly random words, with some extremes and some copies of stored words so that
	// duplicates exist and search has to return the first match.
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2 && sb.n_words > 0)
			return sb.words[$urandom_range(0, sb.n_words - 1)];
		if (r < 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		logic [2:0]  act;
		logic [7:0]  pos;
		logic [31:0] val;
		int          roll;
		int          n;
		int          next_fill;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: empty checks, position bounds, extremes, first match, spare codes.
		send_item(ACT_SEARCH, 8'd0, 32'h0000_0000);
		send_item(ACT_READ, 8'd1, 32'h0000_0000);
		send_item(ACT_DELETE, 8'd0, 32'h0000_0000);
		send_item(ACT_INSERT, 8'd0, 32'h1111_1111);
		send_item(ACT_INSERT, 8'd2, 32'h2222_2222);
		send_item(ACT_APPEND, 8'd255, 32'h8000_0000);
		send_item(ACT_APPEND, 8'd0, 32'h7fff_ffff);
		send_item(ACT_INSERT, 8'd1, 32'hffff_ffff);
		send_item(ACT_INSERT, 8'd4, 32'h0000_0000);
		send_item(ACT_INSERT, 8'd255, 32'h5555_5555);
		send_item(ACT_READ, 8'd0, 32'hffff_ffff);
		send_item(ACT_READ, 8'd4, 32'h0000_0000);
		send_item(ACT_READ, 8'd5, 32'h0000_0000);
		send_item(ACT_READ, 8'd255, 32'h0000_0000);
		send_item(ACT_SEARCH, 8'd0, 32'h7fff_ffff);
		send_item(ACT_APPEND, 8'd0, 32'h8000_0000);
		send_item(ACT_SEARCH, 8'd255, 32'h8000_0000);
		send_item(ACT_SEARCH, 8'd0, 32'h1234_5678);
		send_item(ACT_DELETE, 8'd6, 32'h0000_0000);
		send_item(ACT_DELETE, 8'd1, 32'h0000_0000);
		send_item(ACT_DELETE, 8'd4, 32'h0000_0000);
		send_item(ACT_SPARE6, 8'd0, 32'h0000_0000);
		send_item(ACT_SPARE7, 8'd255, 32'hffff_ffff);
		send_item(ACT_CLEAR, 8'd170, 32'haaaa_aaaa);
		send_item(ACT_READ, 8'd1, 32'h0000_0000);

		next_fill = 50;
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent >= next_fill) begin
				// Fill the array to capacity, then exercise the full and last-slot cases.
				next_fill += FILL_EVERY;
				send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), $urandom);
				while (sb.n_words < CAPACITY)
					send_item(ACT_APPEND, 8'($urandom_range(0, 255)), pick_word());
				send_item(ACT_APPEND, 8'($urandom_range(0, 255)), pick_word());
				send_item(ACT_INSERT, 8'($urandom_range(0, 255)), pick_word());
				send_item(ACT_SEARCH, 8'($urandom_range(0, 255)), sb.words[CAPACITY - 1]);
				send_item(ACT_READ, 8'(CAPACITY), $urandom);
				send_item(ACT_DELETE, 8'd1, $urandom);
				send_item(ACT_INSERT, 8'(CAPACITY), pick_word());
			end
			roll = $urandom_range(0, 99);
			pos  = 8'($urandom_range(0, 255));
			val  = pick_word();
			n    = sb.n_words;
			if (roll < 1) begin
				act = ACT_CLEAR;
			end else if (roll < 26) begin
				act = ACT_APPEND;
			end else if (roll < 41) begin
				act = ACT_INSERT;
				if ($urandom_range(0, 6) != 0)
					pos = 8'($urandom_range(1, n + 1));
			end else if (roll < 58) begin
				act = ACT_DELETE;
				if (n > 0 && $urandom_range(0, 6) != 0)
					pos = 8'($urandom_range(1, n));
			end else if (roll < 70) begin
				act = ACT_READ;
				if (n > 0 && $urandom_range(0, 6) != 0)
					pos = 8'($urandom_range(1, n));
			end else if (roll < 96) begin
				act = ACT_SEARCH;
				if (n > 0 && $urandom_range(0, 9) < 6)
					val = sb.words[$urandom_range(0, n - 1)];
			end else begin
				act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
			end
			send_item(act, pos, val);
		end

		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: a long hold-off early on so the block backs up, then segments of
	// free flow, random stalls, periodic stalls and stall-then-drain.
	initial begin
		int mode;
		int seg;
		int k;
		int cyc;
		m_tready = 1'b0;
		@(posedge arst_n);
		repeat (200) @(negedge clk) m_tready <= ($urandom_range(0, 3) != 0);
		@(negedge clk) m_tready <= 1'b0;
		repeat (600) @(negedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 300);
			k    = $urandom_range(2, 7);
			for (cyc = 0; cyc < seg; cyc++) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (cyc % k) != 0;
					default: m_tready <= (cyc >= seg / 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(status_t'(m_tuser), m_tdata[31:0], m_tdata[39:32],
				m_tdata[47:40]);
	end

	// Ends the run if neither side moves an item for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
